### hdl/wcp_pkg.sv
// wcp_pkg: types, codes and constants of the wav chunk parser
// no dependencies; imported by every module of the block
`default_nettype none

package wcp_pkg;

  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned TAG_BYTES    = 4;
  localparam int unsigned FMT_BODY     = 16;

  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_MISSING     = 2'd1;
  localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

  localparam logic [1:0] CLASS_MONO8    = 2'd0;
  localparam logic [1:0] CLASS_MONO16   = 2'd1;
  localparam logic [1:0] CLASS_STEREO8  = 2'd2;
  localparam logic [1:0] CLASS_STEREO16 = 2'd3;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_TAG    = 3'd1,
    PH_LEN    = 3'd2,
    PH_FMT    = 3'd3,
    PH_SKIP   = 3'd4,
    PH_DATA   = 3'd5,
    PH_DONE   = 3'd6
  } wcp_phase_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  sample_byte;
    logic [1:0]  status;
    logic [1:0]  format_class;
    logic [15:0] channel_count;
    logic [15:0] sample_bits;
    logic [31:0] sample_rate;
    logic [31:0] data_length;
    logic        last;
  } wcp_result_t;

  typedef struct packed {
    logic        data_vld;
    logic        sum_vld;
    wcp_result_t data_item;
    wcp_result_t sum_item;
  } wcp_push_t;

endpackage

`default_nettype wire

### hdl/wcp_in_if.sv
// wcp_in_if: byte input channel of the wav chunk parser
// no dependencies
`default_nettype none

interface wcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_file;

  modport source (output valid, output in_byte, output end_of_file, input ready);
  modport sink (input valid, input in_byte, input end_of_file, output ready);
endinterface

`default_nettype wire

### hdl/wcp_out_if.sv
// wcp_out_if: result channel of the wav chunk parser
// no dependencies
`default_nettype none

interface wcp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  sample_byte;
  logic [1:0]  status;
  logic [1:0]  format_class;
  logic [15:0] channel_count;
  logic [15:0] sample_bits;
  logic [31:0] sample_rate;
  logic [31:0] data_length;
  logic        last;

  modport source (output valid, output kind, output sample_byte, output status,
                  output format_class, output channel_count, output sample_bits,
                  output sample_rate, output data_length, output last, input ready);
  modport sink (input valid, input kind, input sample_byte, input status,
                input format_class, input channel_count, input sample_bits,
                input sample_rate, input data_length, input last, output ready);
endinterface

`default_nettype wire

### hdl/wcp_core.sv
// wcp_core: chunk walker state and per-byte result generation
// depends on wcp_pkg
`default_nettype none

module wcp_core import wcp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       end_of_file_i,
  output wcp_push_t       push_o
);

  wcp_phase_e  phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] rem_q, rem_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] total_q, total_d;
  logic        fmt_q, fmt_d;
  logic        data_q, data_d;

  logic        done;
  logic        emit_data;
  logic        emit_sum;
  logic [1:0]  status;
  logic [1:0]  fclass;
  logic [31:0] rem_len;

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    tag_d     = tag_q;
    rem_d     = rem_q;
    chan_d    = chan_q;
    rate_d    = rate_q;
    bits_d    = bits_q;
    total_d   = total_q;
    fmt_d     = fmt_q;
    data_d    = data_q;
    done      = 1'b0;
    emit_data = 1'b0;
    rem_len   = rem_q;

    unique case (phase_q)
      PH_HEADER: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(HEADER_BYTES - 1)) begin
          phase_d = PH_TAG;
          cnt_d   = '0;
        end
      end
      PH_TAG: begin
        tag_d = {tag_q[23:0], in_byte_i};
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(TAG_BYTES - 1)) begin
          phase_d = PH_LEN;
          cnt_d   = '0;
          rem_d   = '0;
        end
      end
      PH_LEN: begin
        case (cnt_q[1:0])
          2'd0:    rem_len[7:0]   = in_byte_i;
          2'd1:    rem_len[15:8]  = in_byte_i;
          2'd2:    rem_len[23:16] = in_byte_i;
          default: rem_len[31:24] = in_byte_i;
        endcase
        rem_d = rem_len;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(TAG_BYTES - 1)) begin
          cnt_d = '0;
          if (tag_q == TAG_FMT) begin
            fmt_d   = 1'b1;
            phase_d = PH_FMT;
          end else if (tag_q == TAG_DATA) begin
            data_d  = 1'b1;
            total_d = rem_len;
            if (rem_len != '0) phase_d = PH_DATA;
            else               done    = 1'b1;
          end else begin
            if (rem_len != '0) phase_d = PH_SKIP;
            else               done    = 1'b1;
          end
        end
      end
      PH_FMT: begin
        case (cnt_q)
          4'd2:    chan_d[7:0]   = in_byte_i;
          4'd3:    chan_d[15:8]  = in_byte_i;
          4'd4:    rate_d[7:0]   = in_byte_i;
          4'd5:    rate_d[15:8]  = in_byte_i;
          4'd6:    rate_d[23:16] = in_byte_i;
          4'd7:    rate_d[31:24] = in_byte_i;
          4'd14:   bits_d[7:0]   = in_byte_i;
          4'd15:   bits_d[15:8]  = in_byte_i;
          default: ;
        endcase
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(FMT_BODY - 1)) begin
          cnt_d = '0;
          rem_d = (rem_q > 32'(FMT_BODY)) ? rem_q - 32'(FMT_BODY) : '0;
          if (rem_q > 32'(FMT_BODY)) phase_d = PH_SKIP;
          else                       done    = 1'b1;
        end
      end
      PH_SKIP: begin
        rem_d = rem_q - 32'd1;
        if (rem_q == 32'd1) done = 1'b1;
      end
      PH_DATA: begin
        emit_data = 1'b1;
        rem_d     = rem_q - 32'd1;
        if (rem_q == 32'd1) done = 1'b1;
      end
      PH_DONE: ;
      default: phase_d = PH_DONE;
    endcase

    // chunk end: finish when both chunks are known, else look for the next tag
    if (done && !(fmt_d && data_d)) begin
      done    = 1'b0;
      phase_d = PH_TAG;
      cnt_d   = '0;
    end

    emit_sum = 1'b0;
    if (phase_q != PH_DONE && phase_q <= PH_DATA && (done || end_of_file_i)) begin
      emit_sum = 1'b1;
      phase_d  = PH_DONE;
    end
  end

  always_comb begin
    status = STATUS_UNSUPPORTED;
    fclass = CLASS_MONO8;
    if (!fmt_d || !data_d) begin
      status = STATUS_MISSING;
    end else if (chan_d == 16'd1 && bits_d == 16'd8) begin
      status = STATUS_OK;
      fclass = CLASS_MONO8;
    end else if (chan_d == 16'd1 && bits_d == 16'd16) begin
      status = STATUS_OK;
      fclass = CLASS_MONO16;
    end else if (chan_d == 16'd2 && bits_d == 16'd8) begin
      status = STATUS_OK;
      fclass = CLASS_STEREO8;
    end else if (chan_d == 16'd2 && bits_d == 16'd16) begin
      status = STATUS_OK;
      fclass = CLASS_STEREO16;
    end
  end

  always_comb begin
    push_o                        = '0;
    push_o.data_vld               = accept_i && emit_data;
    push_o.sum_vld                = accept_i && emit_sum;
    push_o.data_item.kind         = KIND_DATA;
    push_o.data_item.sample_byte  = in_byte_i;
    push_o.sum_item.kind          = KIND_SUMMARY;
    push_o.sum_item.status        = status;
    push_o.sum_item.format_class  = fclass;
    push_o.sum_item.channel_count = chan_d;
    push_o.sum_item.sample_bits   = bits_d;
    push_o.sum_item.sample_rate   = rate_d;
    push_o.sum_item.data_length   = total_d;
    push_o.sum_item.last          = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      cnt_q   <= '0;
      tag_q   <= '0;
      rem_q   <= '0;
      chan_q  <= '0;
      rate_q  <= '0;
      bits_q  <= '0;
      total_q <= '0;
      fmt_q   <= 1'b0;
      data_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      tag_q   <= tag_d;
      rem_q   <= rem_d;
      chan_q  <= chan_d;
      rate_q  <= rate_d;
      bits_q  <= bits_d;
      total_q <= total_d;
      fmt_q   <= fmt_d;
      data_q  <= data_d;
    end
  end

  // the run ends once and stays ended
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DONE |=> phase_q == PH_DONE)
    else $error("parser left the done phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.sum_vld |=> phase_q == PH_DONE)
    else $error("summary without ending the run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.data_vld |-> phase_q == PH_DATA && rem_q != '0)
    else $error("data byte outside a data chunk");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SKIP || phase_q == PH_DATA) |-> rem_q != '0)
    else $error("empty chunk body still being walked");

endmodule

`default_nettype wire

### hdl/wcp_out_fifo.sv
// wcp_out_fifo: three-entry result queue, takes up to two results per cycle
// depends on wcp_pkg
`default_nettype none

module wcp_out_fifo import wcp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire wcp_push_t push_i,
  output logic       room_o,
  output logic       valid_o,
  input  wire logic  ready_i,
  output wcp_result_t head_o
);

  wcp_result_t ent_q [3];
  wcp_result_t ent_d [3];
  logic [1:0]  cnt_q, cnt_d;
  logic        pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = cnt_q != 2'd0;
  assign room_o  = cnt_q <= 2'd1;
  assign head_o  = ent_q[0];

  always_comb begin
    ent_d = ent_q;
    cnt_d = cnt_q;
    if (pop) begin
      ent_d[0] = ent_q[1];
      ent_d[1] = ent_q[2];
      cnt_d    = cnt_q - 2'd1;
    end
    if (push_i.data_vld) begin
      ent_d[cnt_d] = push_i.data_item;
      cnt_d        = cnt_d + 2'd1;
    end
    if (push_i.sum_vld) begin
      ent_d[cnt_d] = push_i.sum_item;
      cnt_d        = cnt_d + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3 || !(push_i.data_vld || push_i.sum_vld))
    else $error("push into a full result queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.data_vld && push_i.sum_vld) |-> cnt_q <= 2'd1)
    else $error("result pair without room for two");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i && !push_i.data_vld && !push_i.sum_vld) |=> $stable(cnt_q))
    else $error("queue depth changed while stalled");

endmodule

`default_nettype wire

### hdl/wav_chunk_parser.sv
// wav_chunk_parser: RIFF/WAVE chunk walker, one file byte per transaction
// depends on wcp_pkg, wcp_in_if, wcp_out_if, wcp_core, wcp_out_fifo
//
// usage
//   in_i  : valid/ready channel, one file byte per transaction plus end_of_file
//           on the last byte. the 12-byte riff header is skipped, then chunks
//           are walked by tag and little-endian length.
//   out_o : valid/ready channel of results. kind 0 carries one byte of the
//           data chunk, kind 1 (last set) is the summary with status, format
//           class and the fmt fields. the summary ends the run; later input
//           bytes are taken and dropped until reset.
//   queueing: each result is written into the queue and presented from it, behind
//           any results already queued. one byte per cycle while in_i.ready is
//           high; the byte whose transaction both passes the final data byte and
//           ends the run gives two results, queued together, data byte first.
//   stalls: results go to a three-entry queue; in_i.ready is high while the
//           queue holds at most one result, so one pending result never
//           blocks input and a stalled receiver fills the queue and then
//           stops input.
//   reset: rst_ni low clears the queue and puts the walker at the start of
//           the header, with all fields and flags at zero.
`default_nettype none

module wav_chunk_parser import wcp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  wcp_in_if.sink     in_i,
  wcp_out_if.source  out_o
);

  wcp_push_t   push;
  wcp_result_t head;
  logic        room;
  logic        accept;

  assign in_i.ready = room;
  assign accept     = in_i.valid && room;

  wcp_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_byte_i     (in_i.in_byte),
    .end_of_file_i (in_i.end_of_file),
    .push_o        (push)
  );

  wcp_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .head_o  (head)
  );

  assign out_o.kind          = head.kind;
  assign out_o.sample_byte   = head.sample_byte;
  assign out_o.status        = head.status;
  assign out_o.format_class  = head.format_class;
  assign out_o.channel_count = head.channel_count;
  assign out_o.sample_bits   = head.sample_bits;
  assign out_o.sample_rate   = head.sample_rate;
  assign out_o.data_length   = head.data_length;
  assign out_o.last          = head.last;

endmodule

`default_nettype wire
